// ===== rtl/integer_to_ascii_text_unit_macros.svh =====
// Assertion macros shared by the integer-to-ASCII text unit.
`ifndef INTEGER_TO_ASCII_TEXT_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_TEXT_UNIT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define I2A_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an implication on every rising edge of clk while rst_n is high.
`define I2A_ASSERT_IMPL(lbl, ante, cons, msg) \
  `I2A_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/i2a_pkg.sv =====
// Types, constants and helper functions for the integer-to-ASCII text unit.
`default_nettype none
package i2a_pkg;

  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int DEC_BITS   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int HEX32_DIGS = 8;
  localparam int HEX64_DIGS = 16;
  localparam int NCNT_W     = 5;
  localparam int BITCNT_W   = 5;

  localparam logic [MODE_W-1:0] MODE_DEC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEX32 = 2'd1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] HEX_GAP  = 8'h10 - 8'h09;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } i2a_state_t;

  // ASCII code of one hex digit, uppercase letters.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    c = {4'h0, nib} + CH_ZERO;
    if (c > CH_NINE) begin
      c = c + HEX_GAP;
    end
    return c;
  endfunction

  // Add-3 correction of every BCD digit before the next shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    logic [3:0]       nib;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      nib = b[4*i +: 4];
      r[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2a_if.sv =====
// Valid/ready channel interfaces for the input numbers and output characters.
`default_nettype none
interface i2a_in_if
  import i2a_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface i2a_out_if
  import i2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/integer_to_ascii_text_unit.sv =====
// Top level: converts one integer per transfer into ASCII characters, one per output transfer.
// Hex items are loaded into the digit register, then give one character per cycle when unstalled.
// Decimal items run a 32-step shift-and-add-3 loop (one step per cycle on a single adjust unit),
// then each digit position in turn, dropped or printed, after a minus sign for negative numbers.
// The input is ready only while no conversion is in progress; one number is worked at a time.
// rst_n is synchronous and active low; it clears the sequencer and the output valid flag.
`default_nettype none
`include "integer_to_ascii_text_unit_macros.svh"
module integer_to_ascii_text_unit
  import i2a_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  i2a_in_if.sink     in_chan,
  i2a_out_if.source  out_chan
);

  // Sequencer state and the digit register. During decimal conversion the top 40 bits
  // of dig_r hold the BCD accumulator; during emission dig_r shifts left one nibble per
  // digit position so the digit to print is always in the top nibble.
  i2a_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0]  dig_r, dig_nxt;
  logic [DEC_BITS-1:0] mag_r, mag_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NCNT_W-1:0]   n_r, n_nxt;
  logic [1:0]          pre_r, pre_nxt;
  logic                skip_r, skip_nxt;
  logic                dec_r, dec_nxt;

  // Output register: a character waits here until the sink takes it.
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_fire;
  logic                slot_free;
  logic [DEC_BITS-1:0] raw;
  logic [BCD_W-1:0]    bcd_adj;
  logic [3:0]          top_nib;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_fire            = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.char_code = out_char_r;
  assign out_chan.last      = out_last_r;

  // The output register can take a new character when it is empty or being drained.
  assign slot_free = !out_valid_r || out_chan.ready;
  assign raw       = in_chan.value[DEC_BITS-1:0];
  assign top_nib   = dig_r[VALUE_W-1 -: 4];
  assign bcd_adj   = bcd_adjust(dig_r[VALUE_W-1 -: BCD_W]);

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    mag_nxt       = mag_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    pre_nxt       = pre_r;
    skip_nxt      = skip_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.mode == MODE_DEC) begin
            // The magnitude is formed in unsigned arithmetic, so the most negative
            // value gives 2147483648 with no overflow.
            mag_nxt   = raw[DEC_BITS-1] ? (DEC_BITS'(0) - raw) : raw;
            dig_nxt   = '0;
            cnt_nxt   = '0;
            n_nxt     = NCNT_W'(BCD_DIGITS);
            pre_nxt   = raw[DEC_BITS-1] ? 2'd1 : 2'd0;
            skip_nxt  = 1'b1;
            dec_nxt   = 1'b1;
            state_nxt = ST_CONV;
          end else if (in_chan.mode == MODE_HEX32) begin
            dig_nxt   = {raw, {(VALUE_W-DEC_BITS){1'b0}}};
            n_nxt     = NCNT_W'(HEX32_DIGS);
            pre_nxt   = 2'd2;
            skip_nxt  = 1'b0;
            dec_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end else begin
            // The unused mode code decodes as 64-bit hex.
            dig_nxt   = in_chan.value;
            n_nxt     = NCNT_W'(HEX64_DIGS);
            pre_nxt   = 2'd2;
            skip_nxt  = 1'b0;
            dec_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_CONV: begin
        // One shift-and-add-3 step per cycle, magnitude bits enter MSB first.
        dig_nxt[VALUE_W-1 -: BCD_W] = {bcd_adj[BCD_W-2:0], mag_r[DEC_BITS-1]};
        mag_nxt = {mag_r[DEC_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BITCNT_W'(DEC_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          if (pre_r != 2'd0) begin
            // Prefix: a minus sign for negative decimals, "0x" for hex.
            out_valid_nxt = 1'b1;
            out_char_nxt  = dec_r ? CH_MINUS : ((pre_r == 2'd2) ? CH_ZERO : CH_X);
            out_last_nxt  = 1'b0;
            pre_nxt       = pre_r - 1'b1;
          end else if (skip_r && (top_nib == 4'd0) && (n_r != NCNT_W'(1))) begin
            // Leading decimal zero: drop it without a transfer. The final digit
            // is always printed, so zero prints as a single '0'.
            dig_nxt = {dig_r[VALUE_W-5:0], 4'h0};
            n_nxt   = n_r - 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = hex_char(top_nib);
            out_last_nxt  = (n_r == NCNT_W'(1));
            dig_nxt       = {dig_r[VALUE_W-5:0], 4'h0};
            n_nxt         = n_r - 1'b1;
            skip_nxt      = 1'b0;
            if (n_r == NCNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    pre_r      <= pre_nxt;
    skip_r     <= skip_nxt;
    dec_r      <= dec_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // A stalled character stays in the output register, unchanged, until it is taken.
  `I2A_ASSERT_CLK(a_out_held, (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_char_r)), "char lost")
  // A decimal number always passes through the conversion loop.
  `I2A_ASSERT_CLK(a_dec_enters_conv, (in_fire && (in_chan.mode == MODE_DEC)) |=> (state_r == ST_CONV), "decimal item skipped conversion")
  // Emission never runs with an empty digit count.
  `I2A_ASSERT_IMPL(a_emit_has_digits, state_r == ST_EMIT, n_r != '0, "emission with no digits left")

endmodule
`default_nettype wire

// ===== verif/integer_to_ascii_text_unit_tb.sv =====
// Self-checking testbench for the integer-to-ASCII text unit: directed and random numbers.
`timescale 1ns / 1ps
module integer_to_ascii_text_unit_tb
  import i2a_pkg::*;
;

  // The package names only the first two mode codes. Mode 3 is unused and is decoded
  // as 64-bit hex, because only bit 1 of the mode selects the wide path.
  localparam logic [MODE_W-1:0] MODE_HEX64 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  localparam int RANDOM_NUMBERS = 190;
  localparam int SETTLE_CYCLES  = 80;       // Longer than one decimal conversion.
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_REPORTS    = 25;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_char_t;

  // Holds the characters each accepted number must produce, oldest first, and checks
  // every output transfer against them.
  class text_scoreboard;
    text_char_t  expected_chars[$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned numbers_by_mode[4];

    function void push_char(logic [CHAR_W-1:0] code, logic is_last);
      text_char_t c;
      c.char_code = code;
      c.last      = is_last;
      expected_chars.push_back(c);
    endfunction

    function logic [CHAR_W-1:0] hex_digit(logic [3:0] nib);
      if (nib < 4'd10) begin
        return CH_ZERO + nib;
      end
      return CH_UPPER_A + (nib - 4'd10);
    endfunction

    function void spell_hex(logic [VALUE_W-1:0] value, int digits);
      push_char(CH_ZERO, 1'b0);
      push_char(CH_X, 1'b0);
      for (int i = digits - 1; i >= 0; i--) begin
        push_char(hex_digit(value[4*i +: 4]), i == 0);
      end
    endfunction

    // Signed decimal of the low word; the magnitude is taken modulo 2**32, so the most
    // negative value comes out as 2147483648 without any special handling.
    function void spell_decimal(logic [DEC_BITS-1:0] raw);
      logic [DEC_BITS-1:0] mag;
      logic [3:0]          digits[$];
      mag = raw[DEC_BITS-1] ? (32'd0 - raw) : raw;
      if (mag == 0) begin
        push_char(CH_ZERO, 1'b1);
        return;
      end
      while (mag != 0) begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end
      if (raw[DEC_BITS-1]) begin
        push_char(CH_MINUS, 1'b0);
      end
      foreach (digits[i]) begin
        push_char(CH_ZERO + digits[i], i == digits.size() - 1);
      end
    endfunction

    function void note_number(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
      numbers_by_mode[mode]++;
      if (mode == MODE_DEC) begin
        spell_decimal(value[DEC_BITS-1:0]);
      end else if (mode == MODE_HEX32) begin
        spell_hex({32'd0, value[31:0]}, HEX32_DIGS);
      end else begin
        spell_hex(value, HEX64_DIGS);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic is_last);
      text_char_t exp_c;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected character 0x%02h (last %0b) with nothing pending",
                   $time, code, is_last);
        end
        return;
      end
      exp_c = expected_chars.pop_front();
      chars_checked++;
      if (code !== exp_c.char_code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] char_code mismatch: expected 0x%02h, got 0x%02h",
                   $time, exp_c.char_code, code);
        end
      end
      if (is_last !== exp_c.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] last mismatch: expected %0b, got %0b", $time, exp_c.last, is_last);
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  i2a_in_if  in_chan ();
  i2a_out_if out_chan ();

  integer_to_ascii_text_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  text_scoreboard board = new();

  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  int          steady_left = 0;
  int          ready_roll;
  bit          recv_free   = 1'b0;
  bit          send_free   = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Watchdog. The slowest correct run is far below this limit, even when every
  // character waits out the longest receiver stall.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d characters still pending",
               $time, cycle_count, board.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver. The transfer is judged on the values present just before the edge, then
  // ready is chosen for the next cycle. Mostly ready, with short stalls, a few long
  // ones, and stretches of steady acceptance. Ready gets exactly one assignment per edge.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      board.check_char(out_chan.char_code, out_chan.last);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (recv_free || steady_left > 0) begin
      if (steady_left > 0) begin
        steady_left = steady_left - 1;
      end
      out_chan.ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_chan.ready <= 1'b1;
      end else if (ready_roll < 62) begin
        steady_left = $urandom_range(20, 60);
        out_chan.ready <= 1'b1;
      end else if (ready_roll < 92) begin
        stall_left = $urandom_range(0, 2);
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_chan.ready <= 1'b0;
      end
    end
  end

  // Idle time before the next number: usually none or a few cycles, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (send_free || roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Presents one number and holds it until the transfer happens. With no gap the valid
  // stays high and only the payload changes, so valid never sees two assignments in a step.
  task automatic send_number(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mode  <= mode;
    in_chan.value <= value;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
    board.note_number(mode, value);
  endtask

  // Lowers valid and waits until every pending character has come out, then lets the
  // block settle for one more conversion time.
  task automatic drain_all();
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random mode: decimal and 64-bit hex dominate, the unused code still appears.
  function automatic logic [MODE_W-1:0] pick_mode();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return MODE_DEC;
    end else if (roll < 6) begin
      return MODE_HEX32;
    end else if (roll < 9) begin
      return MODE_HEX64;
    end
    return MODE_SPARE;
  endfunction

  // Random value in several shapes, so that every decimal length, both signs, small
  // numbers near zero and single-bit patterns all turn up. Upper bits are random junk
  // in most shapes, which the 32-bit modes must ignore.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    longint unsigned    scale;
    int                 ndig;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, 32'($urandom_range(0, 20))};
      2: v = {$urandom, 32'd0 - 32'($urandom_range(1, 20))};
      3: begin
        ndig  = $urandom_range(1, 10);
        scale = 1;
        repeat (ndig) scale = scale * 10;
        v = {$urandom, 32'(longint'({$urandom, $urandom}) % scale)};
        if ($urandom_range(0, 1) == 1) begin
          v[31:0] = 32'd0 - v[31:0];
        end
      end
      4: v = 64'd1 << $urandom_range(0, 63);
      default: v = ~(64'd1 << $urandom_range(0, 63));
    endcase
    return v;
  endfunction

  initial begin
    int total;
    in_chan.valid  = 1'b0;
    in_chan.mode   = MODE_DEC;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed numbers: zero, one-digit and ten-digit decimals, both signs, the most
    // negative value, junk in the upper word of the 32-bit modes, hex extremes, and the
    // unused mode code.
    send_number(MODE_DEC, 64'd0);
    send_number(MODE_DEC, 64'd9);
    send_number(MODE_DEC, 64'd10);
    send_number(MODE_DEC, 64'h0000_0000_FFFF_FFFF);
    send_number(MODE_DEC, 64'h0000_0000_FFFF_FFF6);
    send_number(MODE_DEC, 64'h0000_0000_7FFF_FFFF);
    send_number(MODE_DEC, 64'h0000_0000_8000_0000);
    send_number(MODE_DEC, 64'h0000_0000_8000_0001);
    send_number(MODE_DEC, 64'd1000000000);
    send_number(MODE_DEC, 64'hFFFF_FFFF_0000_0000);
    send_number(MODE_DEC, 64'hDEAD_BEEF_0000_0007);
    send_number(MODE_HEX32, 64'd0);
    send_number(MODE_HEX32, 64'h0000_0000_FFFF_FFFF);
    send_number(MODE_HEX32, 64'hA5A5_A5A5_1234_5678);
    send_number(MODE_HEX32, 64'hFFFF_FFFF_9ABC_DEF0);
    send_number(MODE_HEX64, 64'd0);
    send_number(MODE_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(MODE_HEX64, 64'h0123_4567_89AB_CDEF);
    send_number(MODE_SPARE, 64'hFEDC_BA98_7654_3210);
    send_number(MODE_SPARE, 64'd0);

    // Random part in three stretches: normal idling on both sides, then a full drain,
    // then back-to-back with no idling at all, then normal idling again.
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == RANDOM_NUMBERS / 3) begin
        drain_all();
        send_free = 1'b1;
        recv_free = 1'b1;
      end
      if (i == RANDOM_NUMBERS / 2) begin
        send_free = 1'b0;
        recv_free = 1'b0;
      end
      send_number(pick_mode(), pick_value());
    end

    in_chan.valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    total = board.numbers_by_mode[0] + board.numbers_by_mode[1] +
            board.numbers_by_mode[2] + board.numbers_by_mode[3];
    $display("Converted %0d numbers: %0d decimal, %0d 32-bit hex, %0d 64-bit hex, %0d spare",
             total, board.numbers_by_mode[0], board.numbers_by_mode[1],
             board.numbers_by_mode[2], board.numbers_by_mode[3]);
    $display("Compared %0d characters under random stalls, %0d errors, %0d cycles",
             board.chars_checked, board.mismatches, cycle_count);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
